// File: design/seq_pkg.sv
// shared types and constants for the sorted event queue
// depends on nothing; imported by sorted_event_queue
package seq_pkg;

  localparam int NAME_W          = 4;
  localparam int PID_W           = 16;
  localparam int TIME_W          = 32;
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TIME_BITS   = 32;

  typedef enum logic [1:0] {
    REQ_PUSH,
    REQ_POP,
    REQ_LOOKUP,
    REQ_REMOVE
  } req_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EMPTY,
    ST_NOT_FOUND,
    ST_FULL
  } status_e;

endpackage

// File: design/sorted_event_queue.sv
// sorted event queue: time-ordered store with push, pop, lookup and remove
// one read and one write port memory swept by a small sequencer; uses seq_pkg
// full, empty or first-push cases raise the result strobe in the cycle after accept;
//   else the sequencer scans entries in S_SCAN, plus an S_INS step when a push lands at
//   the head; the scan visits one stored entry per cycle
// busy is low again in the strobe cycle, so the next request can start there
// reset (async, active low) empties the queue; entries need no clearing
module sorted_event_queue #(
  parameter int QUEUE_DEPTH = seq_pkg::DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = seq_pkg::DEF_TIME_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         req_type_i,
  input  logic [seq_pkg::NAME_W-1:0]         entry_name_i,
  input  logic [seq_pkg::PID_W-1:0]          entry_pid_i,
  input  logic [seq_pkg::TIME_W-1:0]         entry_time_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [seq_pkg::NAME_W-1:0]         out_name_o,
  output logic [seq_pkg::PID_W-1:0]          out_pid_o,
  output logic [seq_pkg::TIME_W-1:0]         out_time_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   removed_count_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   entry_count_o,
  output logic                               queue_empty_o
);
  import seq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [NAME_W-1:0]    name;
    logic [PID_W-1:0]     pid;
    logic [TIME_BITS-1:0] tm;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_INS
  } state_e;

  state_e               state_q;
  req_e                 op_q;
  logic [NAME_W-1:0]    name_q;
  logic [PID_W-1:0]     pid_q;
  logic [TIME_BITS-1:0] time_q;
  logic [AW-1:0]        idx_q;
  logic [CW-1:0]        cnt_q;
  logic [CW-1:0]        kept_q;
  logic [CW-1:0]        removed_q;
  logic                 done_q;
  status_e              status_q;
  logic [NAME_W-1:0]    out_name_q;
  logic [PID_W-1:0]     out_pid_q;
  logic [TIME_W-1:0]    out_time_q;

  entry_t               mem_q [QUEUE_DEPTH];
  entry_t               rd_q;

  req_e                 req_in;
  logic                 accept;
  entry_t               in_ent;
  entry_t               new_ent;
  logic [CW-1:0]        cnt_m1;
  logic                 last;
  logic                 later;
  logic                 hit_lk;
  logic                 hit_rm;
  logic [CW-1:0]        kept_nx;
  logic [CW-1:0]        removed_nx;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_raddr;
  entry_t               mem_wdata;

  assign req_in  = req_e'(req_type_i);
  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign in_ent  = '{name: entry_name_i, pid: entry_pid_i, tm: TIME_BITS'(entry_time_i)};
  assign new_ent = '{name: name_q, pid: pid_q, tm: time_q};
  assign cnt_m1  = cnt_q - 1'b1;

  // compare unit on the entry read back this cycle
  assign last       = ((CW'(idx_q) + 1'b1) == cnt_q);
  assign later      = (rd_q.tm >= time_q);
  assign hit_lk     = (name_q == '0) || ((rd_q.name == name_q) && (rd_q.pid == pid_q));
  assign hit_rm     = (rd_q.pid == pid_q) && ((name_q == '0) || (rd_q.name == name_q));
  assign kept_nx    = kept_q + CW'(!hit_rm);
  assign removed_nx = removed_q + CW'(hit_rm);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rd_q;
    mem_raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (req_in == REQ_PUSH) begin
          mem_raddr = cnt_m1[AW-1:0];
        end
        // first push into an empty queue is written straight away
        if (accept && (req_in == REQ_PUSH) && (cnt_q == '0)) begin
          mem_we    = 1'b1;
          mem_wdata = in_ent;
        end
      end
      S_SCAN: begin
        case (op_q)
          REQ_PUSH: begin
            // walk down from the tail, moving later entries up one slot
            mem_raddr = idx_q - 1'b1;
            mem_we    = 1'b1;
            mem_waddr = idx_q + 1'b1;
            mem_wdata = later ? rd_q : new_ent;
          end
          REQ_POP: begin
            mem_raddr = idx_q + 1'b1;
            mem_we    = (idx_q != '0);
            mem_waddr = idx_q - 1'b1;
          end
          REQ_LOOKUP: begin
            mem_raddr = idx_q + 1'b1;
          end
          REQ_REMOVE: begin
            // compact survivors towards the head
            mem_raddr = idx_q + 1'b1;
            mem_we    = !hit_rm;
            mem_waddr = kept_q[AW-1:0];
          end
          default: ;
        endcase
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_wdata = new_ent;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= REQ_PUSH;
      name_q     <= '0;
      pid_q      <= '0;
      time_q     <= '0;
      idx_q      <= '0;
      cnt_q      <= '0;
      kept_q     <= '0;
      removed_q  <= '0;
      done_q     <= 1'b0;
      status_q   <= ST_OK;
      out_name_q <= '0;
      out_pid_q  <= '0;
      out_time_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q       <= req_in;
            name_q     <= entry_name_i;
            pid_q      <= entry_pid_i;
            time_q     <= TIME_BITS'(entry_time_i);
            idx_q      <= '0;
            kept_q     <= '0;
            removed_q  <= '0;
            status_q   <= ST_OK;
            out_name_q <= '0;
            out_pid_q  <= '0;
            out_time_q <= '0;
            case (req_in)
              REQ_PUSH: begin
                if (cnt_q == CW'(QUEUE_DEPTH)) begin
                  status_q <= ST_FULL;
                  done_q   <= 1'b1;
                end else if (cnt_q == '0) begin
                  cnt_q  <= CW'(1);
                  done_q <= 1'b1;
                end else begin
                  idx_q   <= cnt_m1[AW-1:0];
                  state_q <= S_SCAN;
                end
              end
              REQ_POP, REQ_LOOKUP: begin
                if (cnt_q == '0) begin
                  status_q <= ST_EMPTY;
                  done_q   <= 1'b1;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              REQ_REMOVE: begin
                if (cnt_q == '0) begin
                  done_q <= 1'b1;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          case (op_q)
            REQ_PUSH: begin
              if (later) begin
                if (idx_q == '0) begin
                  state_q <= S_INS;
                end else begin
                  idx_q <= idx_q - 1'b1;
                end
              end else begin
                cnt_q   <= cnt_q + 1'b1;
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end
            end
            REQ_POP: begin
              if (idx_q == '0) begin
                out_name_q <= rd_q.name;
                out_pid_q  <= rd_q.pid;
                out_time_q <= TIME_W'(rd_q.tm);
              end
              if (last) begin
                cnt_q   <= cnt_m1;
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                idx_q <= idx_q + 1'b1;
              end
            end
            REQ_LOOKUP: begin
              if (hit_lk) begin
                out_name_q <= rd_q.name;
                out_pid_q  <= rd_q.pid;
                out_time_q <= TIME_W'(rd_q.tm);
                done_q     <= 1'b1;
                state_q    <= S_IDLE;
              end else if (last) begin
                status_q <= ST_NOT_FOUND;
                done_q   <= 1'b1;
                state_q  <= S_IDLE;
              end else begin
                idx_q <= idx_q + 1'b1;
              end
            end
            REQ_REMOVE: begin
              kept_q    <= kept_nx;
              removed_q <= removed_nx;
              if (last) begin
                cnt_q   <= kept_nx;
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                idx_q <= idx_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_INS: begin
          cnt_q   <= cnt_q + 1'b1;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign out_name_o      = out_name_q;
  assign out_pid_o       = out_pid_q;
  assign out_time_o      = out_time_q;
  assign removed_count_o = removed_q;
  assign entry_count_o   = cnt_q;
  assign queue_empty_o   = (cnt_q == '0);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_scan_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CW'(idx_q) < cnt_q))
    else $error("scan index outside held entries");

  a_full_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_in == REQ_PUSH) && (cnt_q == CW'(QUEUE_DEPTH)))
      |=> (done_o && (status_q == ST_FULL) && $stable(cnt_q)))
    else $error("push into full queue not refused at once");

  a_strobe_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == S_IDLE))
    else $error("result strobe while the sequencer is busy");

endmodule
